@@ hw/rtl/ttsw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttsw_pkg
// Shared constants for the text terminal screen writer: default geometry,
// stream field widths, command codes and control characters.
// ----------------------------------------------------------------------------
package ttsw_pkg;

  localparam int ROWS_DEF = 24;
  localparam int COLS_DEF = 60;

  // stream field widths
  localparam int KIND_W   = 4;
  localparam int CHAR_W   = 8;
  localparam int ROW_FW   = 5;
  localparam int COL_FW   = 6;
  localparam int S_DATA_W = 24;  // char, row, col = 19 bits, padded
  localparam int M_DATA_W = 24;  // cell, row, col, visible = 20 bits, padded

  // command codes
  localparam logic [KIND_W-1:0] KIND_PUT     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_SHOW    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_HIDE    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SCROLL  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LF      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FORWARD = 4'd8;

  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] INVERT_BIT = 8'h80;

endpackage

@@ hw/rtl/ttsw_ram.sv @@
// ----------------------------------------------------------------------------
// ttsw_ram
// Simple dual-port cell store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ttsw_ram #(
  parameter int DEPTH  = 1440,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/text_terminal_screen_writer.sv @@
// ----------------------------------------------------------------------------
// text_terminal_screen_writer
// Character-cell text screen with a cursor; one command per input transfer,
// one status/read result per command.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                       | tuser
//  s_*      | in  | char_code[7:0] read_row[12:8] read_col[18:13] | kind[3:0]
//  m_*      | out | cell_value[7:0] cursor_row[12:8]         | -
//           |     | cursor_col[18:13] cursor_visible[19]     |
//
//  Steps: cursor/show/hide/put commands go idle -> finish; read goes idle -> read -> finish.
//  Scroll (command or any cursor step down past the bottom row) and clear walk the
//  whole store through the single write port, then pass the finish step.
//  After reset a clearing pass over every cell runs with s_tready low.
//  One command in flight at a time; a finished result waits in the output
//  register and holds the sequencer only if it is still there at the end
//  of the next command.
// ----------------------------------------------------------------------------
module text_terminal_screen_writer
  import ttsw_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // char_code, read_row, read_col, zero pad
  input  logic [KIND_W-1:0]   s_tuser,  // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // cell_value, cursor_row, cursor_col,
                                        // cursor_visible, zero pad
);

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int PAD_W  = M_DATA_W - CHAR_W - ROW_FW - COL_FW - 1;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] cnt;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic              cursor_on;
  logic [CHAR_W-1:0] cell_hold;
  logic              rd_ok;
  logic              rd_hit;

  // input fields
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_FW-1:0] read_row;
  logic [COL_FW-1:0] read_col;

  assign kind      = s_tuser;
  assign char_code = s_tdata[CHAR_W-1:0];
  assign read_row  = s_tdata[CHAR_W +: ROW_FW];
  assign read_col  = s_tdata[CHAR_W+ROW_FW +: COL_FW];

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  ttsw_ram #(
    .DEPTH  (CELLS),
    .WIDTH  (CHAR_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // command decode and next cursor
  logic              in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic              put_write;
  logic              go_down;
  logic              scroll_req;
  logic [RW-1:0]     row_next;
  logic [CW-1:0]     col_next;
  logic              cnt_last;
  logic [31:0]       src_sum;

  assign in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLS);
  assign rd_addr  = in_range ? ADDR_W'(32'(read_row) * COLS + 32'(read_col)) : '0;
  assign cur_addr = ADDR_W'(32'(cur_row) * COLS + 32'(cur_col));
  assign cnt_last = (32'(cnt) == CELLS - 1);
  assign src_sum  = 32'(cnt) + COLS + 1;

  always_comb begin
    put_write  = 1'b0;
    go_down    = 1'b0;
    scroll_req = 1'b0;
    row_next   = cur_row;
    col_next   = cur_col;
    unique case (kind)
      KIND_PUT: begin
        if (char_code == CODE_CR) begin
          col_next = '0;
        end else if (char_code == CODE_LF) begin
          col_next = '0;
          go_down  = 1'b1;
        end else begin
          put_write = 1'b1;
          if (32'(cur_col) == COLS - 1) begin
            col_next = '0;
            go_down  = 1'b1;
          end else begin
            col_next = cur_col + CW'(1);
          end
        end
      end
      KIND_CLEAR: begin
        row_next = '0;
        col_next = '0;
      end
      KIND_SCROLL: scroll_req = 1'b1;
      KIND_LF: go_down = 1'b1;
      KIND_NEWLINE: begin
        col_next = '0;
        go_down  = 1'b1;
      end
      KIND_FORWARD: begin
        if (32'(cur_col) == COLS - 1) begin
          col_next = '0;
          go_down  = 1'b1;
        end else begin
          col_next = cur_col + CW'(1);
        end
      end
      default: ;
    endcase
    // moving below the bottom row scrolls and keeps the cursor there
    if (go_down) begin
      if (32'(cur_row) == ROWS - 1) begin
        scroll_req = 1'b1;
      end else begin
        row_next = cur_row + RW'(1);
      end
    end
  end

  // memory access steering; scroll reads one row ahead of the write pointer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    mem_raddr = ADDR_W'(COLS);
    unique case (state) inside
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = (32'(cnt) < CELLS - COLS) ? mem_rdata : '0;
        mem_raddr = (src_sum < CELLS) ? ADDR_W'(src_sum) : '0;
      end
      ST_IDLE: begin
        mem_we    = accept && put_write;
        mem_waddr = cur_addr;
        mem_wdata = char_code;
        if (kind == KIND_READ) begin
          mem_raddr = rd_addr;
        end
      end
      ST_READ, ST_FIN: ;
      default: ;
    endcase
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      cursor_on <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // the finish step loads the output register itself
      if (m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state) inside
        ST_INIT: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_row   <= row_next;
            cur_col   <= col_next;
            cell_hold <= '0;
            rd_ok     <= in_range;
            rd_hit    <= cursor_on && (32'(read_row) == 32'(cur_row))
                         && (32'(read_col) == 32'(cur_col));
            cnt       <= '0;
            if (kind == KIND_SHOW) begin
              cursor_on <= 1'b1;
            end else if (kind == KIND_HIDE) begin
              cursor_on <= 1'b0;
            end
            if (kind == KIND_CLEAR) begin
              state <= ST_CLEAR;
            end else if (scroll_req) begin
              state <= ST_SCROLL;
            end else if (kind == KIND_READ) begin
              state <= ST_READ;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_READ: begin
          cell_hold <= rd_ok ? (mem_rdata ^ (rd_hit ? INVERT_BIT : '0)) : '0;
          state     <= ST_FIN;
        end
        ST_SCROLL, ST_CLEAR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {PAD_W'(0), cursor_on, COL_FW'(cur_col), ROW_FW'(cur_row),
                         cell_hold};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command accepted while one is in flight");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < ROWS) && (32'(cur_col) < COLS))
    else $error("cursor outside the screen");

  a_write_bounds: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < CELLS))
    else $error("cell store write outside the screen");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("result produced outside the finish step");

endmodule

@@ sim/tb_text_terminal_screen_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_terminal_screen_writer
// Self-checking bench for the character-cell screen writer. Terminal-like
// command streams (text lines, CR/LF, cursor moves, scrolls, clears and cell
// reads) go in through the slave stream. A scoreboard keeps its own copy of
// the screen, cursor and visibility and checks every status/read transfer
// on the master stream. Sender bursts and receiver stalls vary all run long.
// ----------------------------------------------------------------------------
module tb_text_terminal_screen_writer
  import ttsw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS         = ROWS_DEF;
  localparam int COLS         = COLS_DEF;
  localparam int CELLS        = ROWS * COLS;
  localparam int TOTAL_CMDS   = 1450;
  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PAD_W        = S_DATA_W - CHAR_W - ROW_FW - COL_FW;

  localparam logic [KIND_W-1:0] KIND_TOP = '1;  // highest unused code

  typedef struct packed {
    logic              cursor_visible;
    logic [COL_FW-1:0] cursor_col;
    logic [ROW_FW-1:0] cursor_row;
    logic [CHAR_W-1:0] cell_value;
  } screen_status_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY_4TH,
    RX_RARE
  } rx_mode_t;

  // --------------------------------------------------------------------------
  class screen_scoreboard;
    logic [CHAR_W-1:0] cells [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    bit                shown;
    screen_status_t    expected_q [$];
    int                errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cur_row = 0;
      cur_col = 0;
      shown   = 1'b0;
      errors  = 0;
    endfunction

    function void shift_up();
      for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = '0;
    endfunction

    function void step_row();
      cur_row++;
      if (cur_row > ROWS - 1) begin
        cur_row = ROWS - 1;
        shift_up();
      end
    endfunction

    function void line_break();
      cur_col = 0;
      step_row();
    endfunction

    function void step_col();
      cur_col++;
      if (cur_col > COLS - 1) line_break();
    endfunction

    function void print_byte(logic [CHAR_W-1:0] code);
      if (code == CODE_CR) begin
        cur_col = 0;
      end else if (code == CODE_LF) begin
        line_break();
      end else begin
        cells[cur_row * COLS + cur_col] = code;
        step_col();
      end
    endfunction

    // called for every accepted command transfer
    function void note_cmd(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] code,
                           logic [ROW_FW-1:0] rrow, logic [COL_FW-1:0] rcol);
      screen_status_t st;
      st.cell_value = '0;
      case (kind)
        KIND_PUT:     print_byte(code);
        KIND_READ: begin
          if (rrow < ROWS && rcol < COLS) begin
            st.cell_value = cells[rrow * COLS + rcol];
            if (shown && rrow == cur_row && rcol == cur_col)
              st.cell_value ^= INVERT_BIT;
          end
        end
        KIND_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
          cur_row = 0;
          cur_col = 0;
        end
        KIND_SHOW:    shown = 1'b1;
        KIND_HIDE:    shown = 1'b0;
        KIND_SCROLL:  shift_up();
        KIND_LF:      step_row();
        KIND_NEWLINE: line_break();
        KIND_FORWARD: step_col();
        default: ;
      endcase
      st.cursor_row     = cur_row[ROW_FW-1:0];
      st.cursor_col     = cur_col[COL_FW-1:0];
      st.cursor_visible = shown;
      expected_q.push_back(st);
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data);
      screen_status_t got;
      screen_status_t want;
      got = data[$bits(screen_status_t)-1:0];
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
        errors++;
      end
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
        errors++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
        errors++;
      end
      if (got.cursor_visible !== want.cursor_visible) begin
        $error("cursor_visible: expected %0d, got %0d",
               want.cursor_visible, got.cursor_visible);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [KIND_W-1:0]   s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  screen_scoreboard sb = new();

  int       cycle_count = 0;
  int       cmds_sent   = 0;
  int       burst_left  = 0;
  int       rx_hold     = 0;
  rx_mode_t rx_mode     = RX_ALWAYS;
  logic [7:0] rx_phase  = '0;

  text_terminal_screen_writer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_terminal_screen_writer: FAILED **");
      $finish;
    end
  end

  // receiver: stall pattern changes to a random mode after a random hold
  always @(posedge clk) begin
    rx_phase <= rx_phase + 8'd1;
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(20, 300);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_ALWAYS:    m_tready <= 1'b1;
      RX_COIN:      m_tready <= 1'($urandom_range(0, 1));
      RX_EVERY_4TH: m_tready <= (rx_phase[1:0] == 2'd0);
      default:      m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                          input logic [ROW_FW-1:0] rrow, input logic [COL_FW-1:0] rcol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{PAD_W{1'b0}}, rcol, rrow, code};
    do @(posedge clk); while (!s_tready);
    sb.note_cmd(kind, code, rrow, rcol);
    burst_left--;
    cmds_sent++;
  endtask

  // put with junk in the read fields, which put ignores
  task automatic put_byte(input logic [CHAR_W-1:0] code);
    send_cmd(KIND_PUT, code, ROW_FW'($urandom_range(0, 31)),
             COL_FW'($urandom_range(0, 63)));
  endtask

  task automatic send_bare(input logic [KIND_W-1:0] kind);
    send_cmd(kind, CHAR_W'($urandom_range(0, 255)), ROW_FW'($urandom_range(0, 31)),
             COL_FW'($urandom_range(0, 63)));
  endtask

  task automatic read_cell(input int unsigned rrow, input int unsigned rcol);
    send_cmd(KIND_READ, CHAR_W'($urandom_range(0, 255)), rrow[ROW_FW-1:0],
             rcol[COL_FW-1:0]);
  endtask

  // one line of text, usually a line ending, then up to three reads, some at or beside the cursor
  task automatic text_line();
    int len;
    int unsigned rrow;
    int unsigned rcol;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 75) : $urandom_range(0, 16);
    repeat (len) begin
      if ($urandom_range(0, 15) == 0) put_byte(CHAR_W'($urandom_range(0, 255)));
      else put_byte(CHAR_W'($urandom_range(8'h20, 8'h7e)));
    end
    case ($urandom_range(0, 4))
      0: begin
        put_byte(CODE_CR);
        put_byte(CODE_LF);
      end
      1: put_byte(CODE_LF);
      2: send_bare(KIND_NEWLINE);
      3: send_bare(KIND_LF);
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) begin
      rrow = $urandom_range(0, 1) ? sb.cur_row : $urandom_range(0, ROWS - 1);
      case ($urandom_range(0, 2))
        0: rcol = sb.cur_col;
        1: rcol = (sb.cur_col > 0) ? sb.cur_col - 1 : 0;
        default: rcol = $urandom_range(0, COLS - 1);
      endcase
      read_cell(rrow, rcol);
    end
  endtask

  task automatic single_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      send_bare(KIND_READ);
    else if (pick < 40) send_bare(KIND_SHOW);
    else if (pick < 50) send_bare(KIND_HIDE);
    else if (pick < 60) send_bare(KIND_FORWARD);
    else if (pick < 68) send_bare(KIND_NEWLINE);
    else if (pick < 76) send_bare(KIND_LF);
    else if (pick < 82) send_bare(KIND_SCROLL);
    else if (pick < 86) send_bare(KIND_CLEAR);
    else if (pick < 94) send_bare(KIND_W'($urandom_range(KIND_FORWARD + 1, KIND_TOP)));
    else                put_byte(CHAR_W'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: fresh store, cursor inversion, byte extremes, bad addresses
    read_cell(0, 0);
    send_bare(KIND_SHOW);
    send_bare(KIND_SHOW);
    read_cell(0, 0);
    put_byte(8'h41);
    put_byte(8'hff);
    put_byte(8'h00);
    put_byte(INVERT_BIT);
    read_cell(0, 0);
    put_byte(CODE_CR);
    read_cell(0, 0);
    send_bare(KIND_HIDE);
    send_bare(KIND_HIDE);
    read_cell(0, 1);
    put_byte(CODE_LF);
    read_cell(31, 63);
    read_cell(ROWS, 0);
    read_cell(0, COLS);
    read_cell(ROWS - 1, COLS - 1);
    send_bare(KIND_FORWARD);
    send_bare(KIND_NEWLINE);
    send_bare(KIND_LF);
    send_bare(KIND_SCROLL);
    send_bare(KIND_W'(KIND_FORWARD + 1));
    send_bare(KIND_TOP);
    send_bare(KIND_CLEAR);

    // random: mostly terminal-style text, some loose commands
    while (cmds_sent < TOTAL_CMDS) begin
      if ($urandom_range(0, 99) < 65) text_line();
      else single_cmd();
    end
    s_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** text_terminal_screen_writer: PASSED **");
    end else begin
      $display("** text_terminal_screen_writer: FAILED **");
    end
    $finish;
  end

endmodule
